/* rtl/i2c_master_transaction_sequencer_defines.svh */
// Assertion macros for the sequencer RTL.
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/i2cmts_pkg.sv */
`timescale 1ns / 1ps
package i2cmts_pkg;

  typedef enum logic [1:0] {
    ACT_POLL  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_RSVD  = 2'd3
  } action_t;

  typedef enum logic [4:0] {
    PH_WAIT_IDLE   = 5'd0,
    PH_WAIT_SB     = 5'd1,
    PH_WAIT_ADDR   = 5'd2,
    PH_EXTRA       = 5'd5,
    PH_WAIT_BTF_RS = 5'd6,
    PH_WAIT_RS_SB  = 5'd7,
    PH_TX_DATA     = 5'd11,
    PH_FINISHED    = 5'd18,
    PH_RX_DATA     = 5'd21,
    PH_ERR_STOP    = 5'd24,
    PH_ERR_WAIT    = 5'd25,
    PH_WAIT_LAST   = 5'd29,
    PH_CLOSING     = 5'd30
  } phase_t;

  localparam int unsigned FB_SB   = 0;
  localparam int unsigned FB_ADDR = 1;
  localparam int unsigned FB_BTF  = 2;
  localparam int unsigned FB_RXNE = 3;
  localparam int unsigned FB_TXE  = 4;
  localparam int unsigned FB_BERR = 5;
  localparam int unsigned FB_ARLO = 6;
  localparam int unsigned FB_AF   = 7;
  localparam int unsigned FB_OVR  = 8;

  localparam logic [8:0] START_FLAG_MASK = 9'h01F;

  localparam logic [1:0] START_NONE  = 2'd0;
  localparam logic [1:0] START_GEN   = 2'd1;
  localparam logic [1:0] START_CLEAR = 2'd2;

  localparam logic [1:0] ACK_KEEP    = 2'd0;
  localparam logic [1:0] ACK_ENABLE  = 2'd1;
  localparam logic [1:0] ACK_DISABLE = 2'd2;

  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_NACK = 3'd1;
  localparam logic [2:0] ERR_ARLO = 3'd2;
  localparam logic [2:0] ERR_BERR = 3'd3;
  localparam logic [2:0] ERR_OVR  = 3'd4;

  typedef struct packed {
    logic [1:0]  action;
    logic [6:0]  dev_addr;
    logic [25:0] extra_word;
    logic [15:0] length;
    logic [8:0]  status_flags;
    logic        bus_busy;
    logic [7:0]  tx_byte;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        reply;
    logic [1:0]  start_cmd;
    logic [1:0]  ack_cmd;
    logic        stop_cmd;
    logic        dr_write_valid;
    logic [7:0]  dr_write_byte;
    logic        tx_taken;
    logic        rx_valid;
    logic [7:0]  rx_data;
    logic        busy_res;
    logic [2:0]  error_code;
  } out_item_t;

endpackage

/* rtl/i2c_master_transaction_sequencer.sv */
`timescale 1ns / 1ps
// I2C master transaction sequencer.
// The input channel (in_valid, in_stall, in_data) carries start items, which
// load a device address, up to three register-address bytes and a length, and
// poll items, which carry the core status flags and take one control step.
// The output channel (out_valid, out_stall, out_data) returns exactly one
// result beat per input beat, in order, with the commands for the core.
// An accepted beat lands in an input register; it passes through the control step
// and is written to the output register once that register is free or being
// taken, and its result then stays on out_data until the receiver takes it.
// The block takes one beat per cycle while out_stall is low, with a single
// control step between the input and output registers.
// When the receiver stalls, the result holds in the output register; one more
// input beat is taken only if the input register is empty, else in_stall is high.
// Synchronous reset empties both registers and returns the sequencer to the
// finished idle state with no error latched.
`include "i2c_master_transaction_sequencer_defines.svh"

module i2c_master_transaction_sequencer (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  i2cmts_pkg::in_item_t   in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output i2cmts_pkg::out_item_t  out_data
);
  import i2cmts_pkg::*;

  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_data_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      advance;
  logic      in_take;

  phase_t      phase_r, phase_nxt;
  logic        active_r, active_nxt;
  logic        is_write_r, is_write_nxt;
  logic [6:0]  target_r, target_nxt;
  logic [23:0] extra_bytes_r, extra_bytes_nxt;
  logic [1:0]  extra_left_r, extra_left_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [2:0]  err_r, err_nxt;

  logic       is_start;
  logic       reject;
  logic [8:0] flags;
  logic       do_extra, do_tx, do_rx;
  logic [7:0] extra_sel;

  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && out_stall);

  always_comb begin
    case (extra_left_r)
      2'd1:    extra_sel = extra_bytes_r[7:0];
      2'd2:    extra_sel = extra_bytes_r[15:8];
      2'd3:    extra_sel = extra_bytes_r[23:16];
      default: extra_sel = 8'd0;
    endcase
  end

  always_comb begin
    phase_nxt       = phase_r;
    active_nxt      = active_r;
    is_write_nxt    = is_write_r;
    target_nxt      = target_r;
    extra_bytes_nxt = extra_bytes_r;
    extra_left_nxt  = extra_left_r;
    bytes_left_nxt  = bytes_left_r;
    err_nxt         = err_r;
    out_data_nxt    = '0;
    do_extra        = 1'b0;
    do_tx           = 1'b0;
    do_rx           = 1'b0;
    flags           = s1_data_r.status_flags;
    is_start        = s1_data_r.action inside {ACT_READ, ACT_WRITE};
    reject          = is_start && active_r;

    if (advance) begin
      if (is_start && !active_r) begin
        is_write_nxt    = (s1_data_r.action == ACT_WRITE);
        target_nxt      = s1_data_r.dev_addr;
        extra_bytes_nxt = s1_data_r.extra_word[23:0];
        extra_left_nxt  = s1_data_r.extra_word[25:24];
        bytes_left_nxt  = s1_data_r.length;
        err_nxt         = ERR_NONE;
        phase_nxt       = PH_WAIT_IDLE;
        active_nxt      = 1'b1;
        flags           = s1_data_r.status_flags & START_FLAG_MASK;
      end

      if (!reject && active_nxt) begin
        if (err_nxt == ERR_NONE) begin
          if (flags[FB_AF]) begin
            err_nxt = ERR_NACK;
          end else if (flags[FB_ARLO]) begin
            err_nxt = ERR_ARLO;
          end else if (flags[FB_BERR]) begin
            err_nxt = ERR_BERR;
          end else if (flags[FB_OVR]) begin
            err_nxt = ERR_OVR;
          end
          if (err_nxt != ERR_NONE) begin
            phase_nxt = PH_ERR_STOP;
          end
        end

        case (phase_nxt)
          PH_WAIT_IDLE: begin
            if (!s1_data_r.bus_busy) begin
              out_data_nxt.start_cmd = START_GEN;
              out_data_nxt.ack_cmd   = is_write_nxt ? ACK_DISABLE : ACK_ENABLE;
              phase_nxt              = PH_WAIT_SB;
            end
          end
          PH_WAIT_SB: begin
            if (flags[FB_SB]) begin
              out_data_nxt.start_cmd      = START_CLEAR;
              out_data_nxt.dr_write_valid = 1'b1;
              out_data_nxt.dr_write_byte  =
                {target_nxt, (extra_left_nxt == 2'd0) && !is_write_nxt};
              phase_nxt = PH_WAIT_ADDR;
            end
          end
          PH_WAIT_ADDR: begin
            if (flags[FB_ADDR]) begin
              if (extra_left_nxt != 2'd0) begin
                phase_nxt = PH_EXTRA;
                do_extra  = flags[FB_TXE];
              end else if (is_write_nxt) begin
                phase_nxt = PH_TX_DATA;
                do_tx     = 1'b1;
              end else begin
                phase_nxt = PH_RX_DATA;
                do_rx     = 1'b1;
              end
            end
          end
          PH_EXTRA:     do_extra = flags[FB_TXE];
          PH_WAIT_BTF_RS: begin
            if (flags[FB_BTF]) begin
              out_data_nxt.start_cmd = START_GEN;
              out_data_nxt.ack_cmd   = ACK_ENABLE;
              phase_nxt              = PH_WAIT_RS_SB;
            end
          end
          PH_WAIT_RS_SB: begin
            if (flags[FB_SB]) begin
              out_data_nxt.start_cmd      = START_CLEAR;
              out_data_nxt.dr_write_valid = 1'b1;
              out_data_nxt.dr_write_byte  = {target_nxt, 1'b1};
              phase_nxt                   = PH_RX_DATA;
            end
          end
          PH_TX_DATA:   do_tx = 1'b1;
          PH_RX_DATA:   do_rx = 1'b1;
          PH_WAIT_LAST: begin
            if (flags[FB_BTF]) begin
              out_data_nxt.stop_cmd = 1'b1;
              phase_nxt             = PH_CLOSING;
            end
          end
          PH_CLOSING, PH_ERR_WAIT: begin
            if (!s1_data_r.bus_busy) begin
              active_nxt = 1'b0;
              phase_nxt  = PH_FINISHED;
            end
          end
          PH_ERR_STOP: begin
            out_data_nxt.stop_cmd = 1'b1;
            phase_nxt             = PH_ERR_WAIT;
          end
          default: ;
        endcase

        if (do_extra) begin
          if (extra_left_nxt == 2'd0) begin
            phase_nxt = is_write_nxt ? PH_TX_DATA : PH_WAIT_BTF_RS;
          end else begin
            out_data_nxt.dr_write_valid = 1'b1;
            out_data_nxt.dr_write_byte  = extra_sel;
            extra_left_nxt              = extra_left_nxt - 2'd1;
            if (extra_left_nxt == 2'd0) begin
              phase_nxt = is_write_nxt ? PH_TX_DATA : PH_WAIT_BTF_RS;
            end
          end
        end

        if (do_tx) begin
          if (bytes_left_nxt == 16'd0) begin
            phase_nxt = PH_WAIT_LAST;
          end else if (flags[FB_TXE]) begin
            out_data_nxt.dr_write_valid = 1'b1;
            out_data_nxt.dr_write_byte  = s1_data_r.tx_byte;
            out_data_nxt.tx_taken       = 1'b1;
            bytes_left_nxt              = bytes_left_nxt - 16'd1;
            if (bytes_left_nxt == 16'd0) begin
              phase_nxt = PH_WAIT_LAST;
            end
          end
        end

        if (do_rx) begin
          if (bytes_left_nxt == 16'd0) begin
            out_data_nxt.stop_cmd = 1'b1;
            phase_nxt             = PH_CLOSING;
          end else if (flags[FB_RXNE]) begin
            if (bytes_left_nxt <= 16'd2) begin
              out_data_nxt.ack_cmd = ACK_DISABLE;
            end
            out_data_nxt.rx_valid = 1'b1;
            out_data_nxt.rx_data  = s1_data_r.rx_byte;
            bytes_left_nxt        = bytes_left_nxt - 16'd1;
            if (bytes_left_nxt == 16'd0) begin
              phase_nxt = PH_WAIT_LAST;
            end
          end
        end
      end

      out_data_nxt.reply      = reject;
      out_data_nxt.busy_res   = active_nxt;
      out_data_nxt.error_code = err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      phase_r      <= PH_FINISHED;
      active_r     <= 1'b0;
      is_write_r   <= 1'b0;
      target_r     <= '0;
      extra_bytes_r <= '0;
      extra_left_r <= '0;
      bytes_left_r <= '0;
      err_r        <= ERR_NONE;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      phase_r      <= phase_nxt;
      active_r     <= active_nxt;
      is_write_r   <= is_write_nxt;
      target_r     <= target_nxt;
      extra_bytes_r <= extra_bytes_nxt;
      extra_left_r <= extra_left_nxt;
      bytes_left_r <= bytes_left_nxt;
      err_r        <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  `ASSERT_IMPL(a_idle_finished, !active_r, phase_r == PH_FINISHED)
  `ASSERT_IMPL(a_err_path, active_r && (err_r != ERR_NONE),
               (phase_r == PH_ERR_STOP) || (phase_r == PH_ERR_WAIT))
  `ASSERT_IMPL(a_reject_busy, out_valid_r && out_data_r.reply, out_data_r.busy_res)
  `ASSERT_IMPL(a_one_data_dir, out_valid_r,
               !(out_data_r.rx_valid && out_data_r.dr_write_valid))
  `ASSERT_NEXT(a_advance_fills, advance, out_valid_r)

endmodule
